@@ sv/bqf_pkg.sv @@
package bqf_pkg;

  localparam int DELAY_WIDTH   = 32;
  localparam int ACC_WIDTH     = 64;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int STEP_WIDTH    = 4;

  localparam logic signed [ACC_WIDTH-1:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  // structure modes
  localparam logic [1:0] MODE_DIRECT     = 2'd0;
  localparam logic [1:0] MODE_CANONICAL  = 2'd1;
  localparam logic [1:0] MODE_TRANS_DIR  = 2'd2;
  localparam logic [1:0] MODE_TRANS_CAN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_A0   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_A1   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_A2   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_B1   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_B2   = 3'd5;

  // multiplier coefficient operand
  localparam logic [2:0] COEF_A0 = 3'd0;
  localparam logic [2:0] COEF_A1 = 3'd1;
  localparam logic [2:0] COEF_A2 = 3'd2;
  localparam logic [2:0] COEF_B1 = 3'd3;
  localparam logic [2:0] COEF_B2 = 3'd4;

  // multiplier data operand
  localparam logic [2:0] DSEL_X   = 3'd0;
  localparam logic [2:0] DSEL_XD1 = 3'd1;
  localparam logic [2:0] DSEL_XD2 = 3'd2;
  localparam logic [2:0] DSEL_YD1 = 3'd3;
  localparam logic [2:0] DSEL_YD2 = 3'd4;
  localparam logic [2:0] DSEL_W   = 3'd5;
  localparam logic [2:0] DSEL_Y   = 3'd6;

  // accumulator first operand
  localparam logic [1:0] ABASE_ACC  = 2'd0;
  localparam logic [1:0] ABASE_ZERO = 2'd1;
  localparam logic [1:0] ABASE_LIFT = 2'd2;

  // accumulator second operand
  localparam logic [1:0] BADD_PROD = 2'd0;
  localparam logic [1:0] BADD_NEG  = 2'd1;
  localparam logic [1:0] BADD_LIFT = 2'd2;

  // value scaled into product format
  localparam logic [1:0] LIFT_X   = 2'd0;
  localparam logic [1:0] LIFT_XD1 = 2'd1;
  localparam logic [1:0] LIFT_XD2 = 2'd2;
  localparam logic [1:0] LIFT_YD2 = 2'd3;

  // rounded result destination
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_W    = 3'd1;
  localparam logic [2:0] DST_Y    = 3'd2;
  localparam logic [2:0] DST_XD1  = 3'd3;
  localparam logic [2:0] DST_XD2  = 3'd4;
  localparam logic [2:0] DST_YD1  = 3'd5;
  localparam logic [2:0] DST_YD2  = 3'd6;

  // delay line shifts
  localparam logic [1:0] SHF_NONE   = 2'd0;
  localparam logic [1:0] SHF_DIRECT = 2'd1;
  localparam logic [1:0] SHF_CANON  = 2'd2;

  typedef struct packed {
    logic       x_load;
    logic       mul_en;
    logic [2:0] coef_sel;
    logic [2:0] data_sel;
    logic       acc_en;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [1:0] lift_sel;
    logic [2:0] rnd_dst;
    logic [1:0] shift;
    logic       w_sum;
    logic       out_load;
  } dp_cmd_t;

endpackage

@@ sv/biquad_iir_filter_multiform.sv @@
// Second-order IIR section with four run-time selectable structures (direct, canonical,
// transposed direct, transposed canonical) sharing four saturating 32-bit delay registers
// that are kept across mode changes. One sample is taken per transfer on the in_ channel and
// one filtered, saturated sample leaves per transfer on the out_ channel. All products go
// through one shared multiplier with a registered product and a 64-bit saturating
// accumulator. in_ready is high only while idle, so a new input transfer is taken only once
// the result register has been loaded for the previous sample. A result waiting on the out_
// channel holds the following sample in its last cycle and keeps in_ready low until it is
// taken. Write coefficients and structure_mode through the cfg_ port only while no sample
// is in flight.
module biquad_iir_filter_multiform #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]           in_sample_in,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           out_sample_out,
  input  logic                                     cfg_we,
  input  logic [bqf_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
  input  logic [COEF_WIDTH-1:0]                    cfg_wdata
);

  logic [1:0]                   mode_r;
  logic signed [COEF_WIDTH-1:0] a0_r, a1_r, a2_r, b1_r, b2_r;
  bqf_pkg::dp_cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bqf_pkg::MODE_DIRECT;
      a0_r   <= COEF_WIDTH'(1 << (COEF_WIDTH - 4));
      a1_r   <= '0;
      a2_r   <= '0;
      b1_r   <= '0;
      b2_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bqf_pkg::CFG_MODE: mode_r <= cfg_wdata[1:0];
        bqf_pkg::CFG_A0:   a0_r   <= cfg_wdata;
        bqf_pkg::CFG_A1:   a1_r   <= cfg_wdata;
        bqf_pkg::CFG_A2:   a2_r   <= cfg_wdata;
        bqf_pkg::CFG_B1:   b1_r   <= cfg_wdata;
        bqf_pkg::CFG_B2:   b2_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bqf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_sample_in),
    .coef_a0    (a0_r),
    .coef_a1    (a1_r),
    .coef_a2    (a2_r),
    .coef_b1    (b1_r),
    .coef_b2    (b2_r),
    .sample_out (out_sample_out)
  );

endmodule

@@ sv/bqf_datapath.sv @@
module bqf_datapath #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bqf_pkg::dp_cmd_t               cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic signed [COEF_WIDTH-1:0]   coef_a0,
  input  logic signed [COEF_WIDTH-1:0]   coef_a1,
  input  logic signed [COEF_WIDTH-1:0]   coef_a2,
  input  logic signed [COEF_WIDTH-1:0]   coef_b1,
  input  logic signed [COEF_WIDTH-1:0]   coef_b2,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int DW = bqf_pkg::DELAY_WIDTH;
  localparam int AW = bqf_pkg::ACC_WIDTH;
  localparam int CF = COEF_WIDTH - 4;
  localparam int PW = COEF_WIDTH + DW;

  localparam logic signed [AW-1:0] HALF  = 64'sd1 <<< (CF - 1);
  localparam logic signed [AW-1:0] D_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [AW-1:0] D_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [DW-1:0] S_MAX = DW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] S_MIN = -S_MAX - 32'sd1;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [DW-1:0]           xd1_r, xd2_r, yd1_r, yd2_r;
  logic signed [DW-1:0]           w_r, y_r;
  logic signed [AW-1:0]           prod_r, acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [DW-1:0]         xs;
  logic signed [COEF_WIDTH-1:0] c_op;
  logic signed [DW-1:0]         d_op;
  logic signed [PW-1:0]         mul_full;
  logic signed [AW-1:0]         prod_c;
  logic signed [DW-1:0]         lift_src;
  logic signed [AW-1:0]         lift_v;
  logic signed [AW-1:0]         a_val, b_val, sum, acc_nxt;
  logic signed [AW-1:0]         rnd_full;
  logic signed [DW-1:0]         rnd_val;
  logic signed [DW:0]           wsum_full;
  logic signed [DW-1:0]         wsum_val;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  assign xs = DW'(x_r);

  always_comb begin
    case (cmd.coef_sel)
      bqf_pkg::COEF_A0: c_op = coef_a0;
      bqf_pkg::COEF_A1: c_op = coef_a1;
      bqf_pkg::COEF_A2: c_op = coef_a2;
      bqf_pkg::COEF_B1: c_op = coef_b1;
      bqf_pkg::COEF_B2: c_op = coef_b2;
      default:          c_op = coef_a0;
    endcase
    case (cmd.data_sel)
      bqf_pkg::DSEL_X:   d_op = xs;
      bqf_pkg::DSEL_XD1: d_op = xd1_r;
      bqf_pkg::DSEL_XD2: d_op = xd2_r;
      bqf_pkg::DSEL_YD1: d_op = yd1_r;
      bqf_pkg::DSEL_YD2: d_op = yd2_r;
      bqf_pkg::DSEL_W:   d_op = w_r;
      bqf_pkg::DSEL_Y:   d_op = y_r;
      default:           d_op = xs;
    endcase
    case (cmd.lift_sel)
      bqf_pkg::LIFT_X:   lift_src = xs;
      bqf_pkg::LIFT_XD1: lift_src = xd1_r;
      bqf_pkg::LIFT_XD2: lift_src = xd2_r;
      bqf_pkg::LIFT_YD2: lift_src = yd2_r;
      default:           lift_src = xs;
    endcase
  end

  assign mul_full = c_op * d_op;

  // a product of a coefficient and a 32-bit operand never reaches the limit, so this clamp has no effect
  always_comb begin
    if (prod_r > bqf_pkg::ACC_LIM) begin
      prod_c = bqf_pkg::ACC_LIM;
    end else if (prod_r < -bqf_pkg::ACC_LIM) begin
      prod_c = -bqf_pkg::ACC_LIM;
    end else begin
      prod_c = prod_r;
    end
  end

  assign lift_v = AW'(lift_src) <<< CF;

  always_comb begin
    case (cmd.a_sel)
      bqf_pkg::ABASE_ACC:  a_val = acc_r;
      bqf_pkg::ABASE_ZERO: a_val = '0;
      bqf_pkg::ABASE_LIFT: a_val = lift_v;
      default:             a_val = '0;
    endcase
    case (cmd.b_sel)
      bqf_pkg::BADD_PROD: b_val = prod_c;
      bqf_pkg::BADD_NEG:  b_val = -prod_c;
      bqf_pkg::BADD_LIFT: b_val = lift_v;
      default:            b_val = prod_c;
    endcase
    sum = a_val + b_val;
    if (sum > bqf_pkg::ACC_LIM) begin
      acc_nxt = bqf_pkg::ACC_LIM;
    end else if (sum < -bqf_pkg::ACC_LIM) begin
      acc_nxt = -bqf_pkg::ACC_LIM;
    end else begin
      acc_nxt = sum;
    end
  end

  // round half up, drop coefficient fraction, saturate to delay width
  always_comb begin
    rnd_full = (acc_r + HALF) >>> CF;
    if (rnd_full > D_MAX) begin
      rnd_val = D_MAX[DW-1:0];
    end else if (rnd_full < D_MIN) begin
      rnd_val = D_MIN[DW-1:0];
    end else begin
      rnd_val = rnd_full[DW-1:0];
    end
  end

  always_comb begin
    wsum_full = (DW+1)'(xs) + (DW+1)'(yd1_r);
    if (wsum_full > (DW+1)'(D_MAX)) begin
      wsum_val = D_MAX[DW-1:0];
    end else if (wsum_full < (DW+1)'(D_MIN)) begin
      wsum_val = D_MIN[DW-1:0];
    end else begin
      wsum_val = wsum_full[DW-1:0];
    end
  end

  always_comb begin
    if (y_r > S_MAX) begin
      out_nxt = S_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_r < S_MIN) begin
      out_nxt = S_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_nxt = y_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x_r <= sample_in;
    end
    if (cmd.mul_en) begin
      prod_r <= AW'(mul_full);
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.w_sum) begin
      w_r <= wsum_val;
    end else if (cmd.rnd_dst == bqf_pkg::DST_W) begin
      w_r <= rnd_val;
    end
    if (cmd.rnd_dst == bqf_pkg::DST_Y) begin
      y_r <= rnd_val;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xd1_r <= '0;
      xd2_r <= '0;
      yd1_r <= '0;
      yd2_r <= '0;
    end else begin
      case (cmd.rnd_dst)
        bqf_pkg::DST_XD1: xd1_r <= rnd_val;
        bqf_pkg::DST_XD2: xd2_r <= rnd_val;
        bqf_pkg::DST_YD1: yd1_r <= rnd_val;
        bqf_pkg::DST_YD2: yd2_r <= rnd_val;
        default: ;
      endcase
      case (cmd.shift)
        bqf_pkg::SHF_DIRECT: begin
          xd2_r <= xd1_r;
          xd1_r <= xs;
          yd2_r <= yd1_r;
          yd1_r <= rnd_val;
        end
        bqf_pkg::SHF_CANON: begin
          xd2_r <= xd1_r;
          xd1_r <= w_r;
        end
        default: ;
      endcase
    end
  end

  assign sample_out = out_r;

endmodule

@@ sv/bqf_ctrl.sv @@
module bqf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bqf_pkg::dp_cmd_t  cmd
);

  localparam int SW = bqf_pkg::STEP_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [SW-1:0] LAST_DIRECT = 4'd6;
  localparam logic [SW-1:0] LAST_CANON  = 4'd8;
  localparam logic [SW-1:0] LAST_TDIR   = 4'd7;
  localparam logic [SW-1:0] LAST_TCAN   = 4'd8;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] last_step;
  logic          out_free;

  always_comb begin
    case (mode)
      bqf_pkg::MODE_DIRECT:    last_step = LAST_DIRECT;
      bqf_pkg::MODE_CANONICAL: last_step = LAST_CANON;
      bqf_pkg::MODE_TRANS_DIR: last_step = LAST_TDIR;
      bqf_pkg::MODE_TRANS_CAN: last_step = LAST_TCAN;
      default:                 last_step = LAST_DIRECT;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == last_step) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // schedule: multiply issue, accumulate in the following cycle, round from acc
  always_comb begin
    cmd          = '0;
    cmd.x_load   = in_valid && (state_r == ST_IDLE);
    cmd.out_load = (state_r == ST_DONE) && out_free;
    if (state_r == ST_RUN) begin
      case ({mode, step_r})
        // direct form
        {bqf_pkg::MODE_DIRECT, 4'd0}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A0; cmd.data_sel = bqf_pkg::DSEL_X;
        end
        {bqf_pkg::MODE_DIRECT, 4'd1}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A1; cmd.data_sel = bqf_pkg::DSEL_XD1;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_DIRECT, 4'd2}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A2; cmd.data_sel = bqf_pkg::DSEL_XD2;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_DIRECT, 4'd3}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B1; cmd.data_sel = bqf_pkg::DSEL_YD1;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_DIRECT, 4'd4}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B2; cmd.data_sel = bqf_pkg::DSEL_YD2;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_NEG;
        end
        {bqf_pkg::MODE_DIRECT, 4'd5}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_NEG;
        end
        {bqf_pkg::MODE_DIRECT, 4'd6}: begin
          cmd.rnd_dst = bqf_pkg::DST_Y; cmd.shift = bqf_pkg::SHF_DIRECT;
        end
        // canonical form
        {bqf_pkg::MODE_CANONICAL, 4'd0}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B1; cmd.data_sel = bqf_pkg::DSEL_XD1;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd1}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B2; cmd.data_sel = bqf_pkg::DSEL_XD2;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_LIFT; cmd.b_sel = bqf_pkg::BADD_NEG;
          cmd.lift_sel = bqf_pkg::LIFT_X;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd2}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_NEG;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd3}: begin
          cmd.rnd_dst = bqf_pkg::DST_W;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd4}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A0; cmd.data_sel = bqf_pkg::DSEL_W;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd5}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A1; cmd.data_sel = bqf_pkg::DSEL_XD1;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd6}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A2; cmd.data_sel = bqf_pkg::DSEL_XD2;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd7}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_PROD;
        end
        {bqf_pkg::MODE_CANONICAL, 4'd8}: begin
          cmd.rnd_dst = bqf_pkg::DST_Y; cmd.shift = bqf_pkg::SHF_CANON;
        end
        // transposed direct form
        {bqf_pkg::MODE_TRANS_DIR, 4'd0}: begin
          cmd.w_sum = 1'b1;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd1}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A0; cmd.data_sel = bqf_pkg::DSEL_W;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd2}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B1; cmd.data_sel = bqf_pkg::DSEL_W;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_LIFT; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.lift_sel = bqf_pkg::LIFT_XD1;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd3}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B2; cmd.data_sel = bqf_pkg::DSEL_W;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_LIFT; cmd.b_sel = bqf_pkg::BADD_NEG;
          cmd.lift_sel = bqf_pkg::LIFT_YD2; cmd.rnd_dst = bqf_pkg::DST_Y;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd4}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A1; cmd.data_sel = bqf_pkg::DSEL_W;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_NEG;
          cmd.rnd_dst = bqf_pkg::DST_YD1;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd5}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A2; cmd.data_sel = bqf_pkg::DSEL_W;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_LIFT; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.lift_sel = bqf_pkg::LIFT_XD2; cmd.rnd_dst = bqf_pkg::DST_YD2;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd6}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.rnd_dst = bqf_pkg::DST_XD1;
        end
        {bqf_pkg::MODE_TRANS_DIR, 4'd7}: begin
          cmd.rnd_dst = bqf_pkg::DST_XD2;
        end
        // transposed canonical form
        {bqf_pkg::MODE_TRANS_CAN, 4'd0}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A0; cmd.data_sel = bqf_pkg::DSEL_X;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd1}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A1; cmd.data_sel = bqf_pkg::DSEL_X;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_LIFT; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.lift_sel = bqf_pkg::LIFT_XD1;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd2}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.rnd_dst = bqf_pkg::DST_Y;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd3}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B1; cmd.data_sel = bqf_pkg::DSEL_Y;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd4}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_NEG;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd5}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_A2; cmd.data_sel = bqf_pkg::DSEL_X;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_LIFT;
          cmd.lift_sel = bqf_pkg::LIFT_XD2;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd6}: begin
          cmd.mul_en = 1'b1; cmd.coef_sel = bqf_pkg::COEF_B2; cmd.data_sel = bqf_pkg::DSEL_Y;
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ZERO; cmd.b_sel = bqf_pkg::BADD_PROD;
          cmd.rnd_dst = bqf_pkg::DST_XD1;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd7}: begin
          cmd.acc_en = 1'b1; cmd.a_sel = bqf_pkg::ABASE_ACC; cmd.b_sel = bqf_pkg::BADD_NEG;
        end
        {bqf_pkg::MODE_TRANS_CAN, 4'd8}: begin
          cmd.rnd_dst = bqf_pkg::DST_XD2;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN && step_r == '0))
    else $error("transfer in did not start a run");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= last_step))
    else $error("step counter past last step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");
`endif

endmodule

@@ sim/biquad_checker.sv @@
module biquad_checker #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  input  logic                                cfg_we,
  input  logic [bqf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [COEF_WIDTH-1:0]               cfg_wdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = COEF_WIDTH - 4;

  logic [1:0]                     form;
  longint                         a0, a1, a2, b1, b2;
  longint                         xd1, xd2, yd1, yd2;
  logic signed [SAMPLE_WIDTH-1:0] expected_samples[$];
  int                             fail_count;
  int                             done_count;

  function automatic longint sat_to(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint acc_clamp(input longint v);
    if (v > bqf_pkg::ACC_LIM) return bqf_pkg::ACC_LIM;
    if (v < -bqf_pkg::ACC_LIM) return -bqf_pkg::ACC_LIM;
    return v;
  endfunction

  function automatic longint mac_add(input longint a, input longint b);
    return acc_clamp(a + b);
  endfunction

  function automatic longint prod(input longint c, input longint v);
    return acc_clamp(c * v);
  endfunction

  function automatic longint scale_up(input longint v);
    return v * (longint'(1) <<< FRAC);
  endfunction

  // round half up, drop coefficient fraction, clamp to delay width
  function automatic longint round_delay(input longint acc);
    return sat_to((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC, bqf_pkg::DELAY_WIDTH);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
      input logic signed [SAMPLE_WIDTH-1:0] sample);
    longint x, w, y, acc, n_xd1, n_xd2, n_yd1, n_yd2;
    x = longint'(sample);
    case (form)
      bqf_pkg::MODE_CANONICAL: begin
        acc = mac_add(scale_up(x), -prod(b1, xd1));
        acc = mac_add(acc, -prod(b2, xd2));
        w = round_delay(acc);
        acc = mac_add(prod(a0, w), prod(a1, xd1));
        acc = mac_add(acc, prod(a2, xd2));
        y = round_delay(acc);
        xd2 = xd1;
        xd1 = w;
      end
      bqf_pkg::MODE_TRANS_DIR: begin
        w = sat_to(x + yd1, bqf_pkg::DELAY_WIDTH);
        y = round_delay(mac_add(prod(a0, w), scale_up(xd1)));
        n_yd1 = round_delay(mac_add(scale_up(yd2), -prod(b1, w)));
        n_yd2 = round_delay(-prod(b2, w));
        n_xd1 = round_delay(mac_add(scale_up(xd2), prod(a1, w)));
        n_xd2 = round_delay(prod(a2, w));
        yd1 = n_yd1;
        yd2 = n_yd2;
        xd1 = n_xd1;
        xd2 = n_xd2;
      end
      bqf_pkg::MODE_TRANS_CAN: begin
        y = round_delay(mac_add(prod(a0, x), scale_up(xd1)));
        acc = mac_add(prod(a1, x), -prod(b1, y));
        n_xd1 = round_delay(mac_add(acc, scale_up(xd2)));
        n_xd2 = round_delay(mac_add(prod(a2, x), -prod(b2, y)));
        xd1 = n_xd1;
        xd2 = n_xd2;
      end
      default: begin
        acc = mac_add(prod(a0, x), prod(a1, xd1));
        acc = mac_add(acc, prod(a2, xd2));
        acc = mac_add(acc, -prod(b1, yd1));
        acc = mac_add(acc, -prod(b2, yd2));
        y = round_delay(acc);
        xd2 = xd1;
        xd1 = x;
        yd2 = yd1;
        yd1 = y;
      end
    endcase
    return SAMPLE_WIDTH'(sat_to(y, SAMPLE_WIDTH));
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (!rst_n) begin
      form = bqf_pkg::MODE_DIRECT;
      a0 = longint'(1) <<< FRAC;
      a1 = 0;
      a2 = 0;
      b1 = 0;
      b2 = 0;
      xd1 = 0;
      xd2 = 0;
      yd1 = 0;
      yd2 = 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bqf_pkg::CFG_MODE: form = cfg_wdata[1:0];
          bqf_pkg::CFG_A0:   a0 = longint'(signed'(cfg_wdata));
          bqf_pkg::CFG_A1:   a1 = longint'(signed'(cfg_wdata));
          bqf_pkg::CFG_A2:   a2 = longint'(signed'(cfg_wdata));
          bqf_pkg::CFG_B1:   b1 = longint'(signed'(cfg_wdata));
          bqf_pkg::CFG_B2:   b2 = longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      // result transfer checked before this edge's input transfer is predicted
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample_out %0d, expected nothing", $realtime,
                   out_sample_out);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          done_count++;
          if (out_sample_out !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $realtime,
                     want, out_sample_out);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_samples.push_back(filter_sample(in_sample_in));
    end
    mismatches <= fail_count;
    outstanding <= expected_samples.size();
    compared <= done_count;
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_WIDTH     = 24;
  localparam int ONE            = 1 << (COEF_WIDTH - 4);
  localparam int RANDOM_SAMPLES = 600;
  localparam int STALL_CYCLES   = 200;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [bqf_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bqf_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0]   C_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0]   C_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [SAMPLE_WIDTH-1:0]    out_sample_out;
  logic                              cfg_we;
  logic [bqf_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
  logic [COEF_WIDTH-1:0]             cfg_wdata;

  int errors;
  int pending;
  int results;
  int sent;
  int settings;
  bit steady;
  bit stall_request;

  biquad_iir_filter_multiform #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  biquad_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (errors),
    .outstanding   (pending),
    .compared      (results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: rare random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit reached with %0d results outstanding", pending);
    $display("FAIL biquad_iir_filter_multiform");
    $finish;
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SAMPLE_WIDTH'(int'($urandom_range(512)) - 256);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] pick_wild_coef();
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      default: return COEF_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= value;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [bqf_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_filter(input logic [1:0] mode,
                             input logic signed [COEF_WIDTH-1:0] a0, a1, a2, b1, b2,
                             input bit all_regs);
    logic [COEF_WIDTH-1:0] mode_word;
    wait_idle();
    // junk in the unused upper bits of the mode word
    mode_word = COEF_WIDTH'($urandom);
    mode_word[1:0] = mode;
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_MODE, mode_word);
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_A0, a0);
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_A1, a1);
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_A2, a2);
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_B1, b1);
    if (all_regs || $urandom_range(3) != 0) cfg_write(bqf_pkg::CFG_B2, b2);
    if (all_regs || $urandom_range(3) == 0)
      cfg_write($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, COEF_WIDTH'($urandom));
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    logic signed [SAMPLE_WIDTH-1:0] corner_samples[5];
    logic signed [COEF_WIDTH-1:0]   ca0, ca1, ca2, cb1, cb2;
    int  phase;
    int  count;
    int  random_sent;
    int  b1lim;
    bit  wild;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady = 1'b0;
    stall_request = 1'b0;
    sent = 0;
    settings = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings pass the sample straight through
    corner_samples = '{'0, S_MAX, S_MIN, '1, SAMPLE_WIDTH'(1)};
    foreach (corner_samples[i]) send_sample(corner_samples[i]);

    // every structure at extreme coefficients, delay state carried across modes
    for (int m = 0; m < 4; m++) begin
      load_filter(2'(m), C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample('0);
    end

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      wild = (phase % 4 == 3);
      if (wild) begin
        ca0 = pick_wild_coef();
        ca1 = pick_wild_coef();
        ca2 = pick_wild_coef();
        cb1 = pick_wild_coef();
        cb2 = pick_wild_coef();
      end else begin
        // roughly stable poles so the output keeps moving
        ca0 = COEF_WIDTH'(int'($urandom_range(2 * ONE)) - ONE);
        ca1 = COEF_WIDTH'(int'($urandom_range(2 * ONE)) - ONE);
        ca2 = COEF_WIDTH'(int'($urandom_range(2 * ONE)) - ONE);
        cb2 = COEF_WIDTH'(int'($urandom_range(2 * (ONE * 9 / 10))) - ONE * 9 / 10);
        b1lim = (ONE + int'(cb2)) * 95 / 100;
        cb1 = COEF_WIDTH'(int'($urandom_range(2 * b1lim)) - b1lim);
      end
      load_filter(2'($urandom_range(3)), ca0, ca1, ca2, cb1, cb2, phase == 0);
      if (phase == 2) steady = 1'b1;
      if (phase == 4) stall_request = 1'b1;
      count = (phase == 2) ? 80 : int'($urandom_range(60, 20));
      repeat (count) begin
        send_sample(pick_sample());
        random_sent++;
      end
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples over %0d filter settings, all four structures, one long stall",
             sent, settings);
    $display("%0d results compared, %0d mismatches, %0d outstanding", results, errors,
             pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS biquad_iir_filter_multiform");
    end else begin
      $display("FAIL biquad_iir_filter_multiform");
    end
    $finish;
  end

endmodule
